[rtl/mcts_pkg.sv]
// Package for the MIDI clock tick scheduler: item types, codes and widths.
// Used by mcts_offset, midi_clock_tick_scheduler and the testbench; depends on nothing.
package mcts_pkg;

    // Tick interval precision and tick cap
    localparam int FRAC_BITS  = 16;
    localparam int MAX_TICKS  = 32;
    localparam int TICK_CNT_W = $clog2(MAX_TICKS + 1);

    // Field widths
    localparam int TIME_W  = 64;
    localparam int TEMPO_W = 20;
    localparam int COUNT_W = 32;
    localparam int LOOK_W  = 30;
    localparam int REM_W   = TEMPO_W + 1;

    // 60 s / 24 ticks in ns, times 1000 for milli-BPM: 2.5e12 fits in 42 bits
    localparam logic [63:0] NS_PER_TICK = 64'd2500000000000;
    localparam int WHOLE_W = 42;
    localparam int Q_W     = WHOLE_W + FRAC_BITS;
    localparam int PROD_W  = TIME_W + FRAC_BITS;
    localparam logic [Q_W-1:0] DIVIDEND = Q_W'(NS_PER_TICK) << FRAC_BITS;
    localparam int CYC_W   = $clog2((Q_W > COUNT_W) ? Q_W : COUNT_W);

    localparam logic [LOOK_W-1:0] LOOKAHEAD_RESET = LOOK_W'(200000000);

    // Transport event codes
    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_CONTINUE = 3'd1;
    localparam logic [2:0] MODE_STOP     = 3'd2;
    localparam logic [2:0] MODE_TEMPO    = 3'd3;
    localparam logic [2:0] MODE_PUMP     = 3'd4;

    // MIDI realtime status bytes
    localparam logic [7:0] ST_TICK     = 8'hF8;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_CONTINUE = 8'hFB;
    localparam logic [7:0] ST_STOP     = 8'hFC;

    typedef struct packed {
        logic [2:0]         mode;
        logic [TIME_W-1:0]  event_time_ns;
        logic [TEMPO_W-1:0] bpm_milli;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        status_byte;
        logic [TIME_W-1:0] message_time_ns;
        logic              last;
    } t_out_item;

    // Request to the offset unit
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TEMPO_W-1:0] tempo;
    } t_off_req;

endpackage

[rtl/mcts_offset.sv]
// Bit-serial tick offset unit: interval = 2.5e12/tempo in fixed point, then count * interval.
// Depends on mcts_pkg.
module mcts_offset
    import mcts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  t_off_req            i_req,
    output logic                o_done,
    output logic [Q_W-1:0]      o_q,
    output logic [PROD_W-1:0]   o_prod
);

    typedef enum logic [1:0] {U_IDLE, U_DIV, U_MUL} t_ustate;

    t_ustate             r_state;
    logic                r_done;
    logic [CYC_W-1:0]    r_cyc;
    logic [Q_W-1:0]      r_q;
    logic [REM_W-1:0]    r_rem;
    logic [TEMPO_W-1:0]  r_tempo;
    logic [COUNT_W-1:0]  r_n;
    logic [PROD_W-1:0]   r_prod;

    logic [REM_W-1:0]    trial;
    logic                ge;

    // One restoring step: bring down the next dividend bit
    assign trial = {r_rem[REM_W-2:0], r_q[Q_W-1]};
    assign ge    = (trial >= {1'b0, r_tempo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_cyc   <= '0;
        end else begin
            // flag the last multiply step
            r_done <= (r_state == U_MUL) && (r_cyc == CYC_W'(COUNT_W - 1));
            case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_q     <= DIVIDEND;
                        r_rem   <= '0;
                        r_tempo <= i_req.tempo;
                        r_n     <= i_req.count;
                        r_cyc   <= '0;
                        r_state <= U_DIV;
                    end
                end
                U_DIV: begin
                    // shift dividend out, quotient bits in
                    r_rem <= ge ? (trial - {1'b0, r_tempo}) : trial;
                    r_q   <= {r_q[Q_W-2:0], ge};
                    if (r_cyc == CYC_W'(Q_W - 1)) begin
                        r_cyc   <= '0;
                        r_prod  <= '0;
                        r_state <= U_MUL;
                    end else begin
                        r_cyc <= r_cyc + 1'b1;
                    end
                end
                U_MUL: begin
                    // shift-add, count MSB first, product kept modulo 2^PROD_W
                    r_prod <= {r_prod[PROD_W-2:0], 1'b0}
                              + (r_n[COUNT_W-1] ? PROD_W'(r_q) : '0);
                    r_n    <= {r_n[COUNT_W-2:0], 1'b0};
                    if (r_cyc == CYC_W'(COUNT_W - 1)) begin
                        r_state <= U_IDLE;
                    end else begin
                        r_cyc <= r_cyc + 1'b1;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_prod = r_prod;

endmodule

[rtl/midi_clock_tick_scheduler.sv]
// Top level of the MIDI 24-PPQN clock tick scheduler; instantiates mcts_offset.
// Depends on mcts_pkg.
//
// Start, continue and stop each give one message, loaded into the output
// register from S_EMIT once that register is free, after which the next
// transaction can be taken; set tempo gives none. A pump computes the tick
// interval by a bit-serial divider and the offset of the next tick by a
// bit-serial multiplier; a pump with a pending tempo change on a nonzero old
// tempo, and no pending continue, runs this pair twice. Each tick then passes
// through S_CALC and S_CHK, and the receiver may stall any message. One
// transaction is worked on at a time; a finished message waits in the output
// register while the next transaction is taken.
module midi_clock_tick_scheduler
    import mcts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LOOK_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_EMIT, S_OLD, S_NEW, S_CALC, S_CHK} t_state;

    t_state               r_state;
    logic [LOOK_W-1:0]    r_lookahead;
    logic                 r_running;
    logic [TEMPO_W-1:0]   r_tempo;
    logic [TEMPO_W-1:0]   r_anchored;
    logic [TIME_W-1:0]    r_anchor;
    logic [COUNT_W-1:0]   r_next;
    logic                 r_cont_p;
    logic                 r_tempo_p;

    logic [7:0]           r_status;
    logic [TIME_W-1:0]    r_now;
    logic [TIME_W-1:0]    r_horizon;
    logic [TIME_W-1:0]    r_kept;
    logic [Q_W-1:0]       r_q;
    logic [PROD_W-1:0]    r_acc;
    logic [TIME_W-1:0]    r_t;
    logic [TIME_W-1:0]    r_pend;
    logic                 r_have;
    logic [TICK_CNT_W-1:0] r_cnt;

    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 r_off_start;
    t_off_req             r_off_req;
    logic                 off_done;
    logic [Q_W-1:0]       off_q;
    logic [PROD_W-1:0]    off_prod;
    logic [TIME_W-1:0]    off_ns;

    logic                 accept;
    logic                 out_free;
    logic                 tick_ok;
    logic                 emit;
    logic                 off_go;

    mcts_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_off_start),
        .i_req   (r_off_req),
        .o_done  (off_done),
        .o_q     (off_q),
        .o_prod  (off_prod)
    );

    assign off_ns   = off_prod[PROD_W-1:FRAC_BITS];
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign tick_ok  = (r_cnt < TICK_CNT_W'(MAX_TICKS)) && !(r_t > r_horizon);

    // Load the output register from a transport message or a held tick
    assign emit   = out_free && ((r_state == S_EMIT) || ((r_state == S_CHK) && r_have));
    // Kick the offset unit on a live pump, and again after the old-tempo pass
    assign off_go = (accept && (i_in_data.mode == MODE_PUMP) && r_running
                     && (r_tempo != '0))
                    || ((r_state == S_OLD) && off_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lookahead <= LOOKAHEAD_RESET;
            r_running   <= 1'b0;
            r_tempo     <= '0;
            r_anchored  <= '0;
            r_anchor    <= '0;
            r_next      <= '0;
            r_cont_p    <= 1'b0;
            r_tempo_p   <= 1'b0;
            r_out_valid <= 1'b0;
            r_off_start <= 1'b0;
            r_have      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_off_start <= off_go;
            r_out_valid <= emit || (r_out_valid && i_out_stall);

            // configuration write
            if (i_cfg_valid)
                r_lookahead <= i_cfg_data;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now <= i_in_data.event_time_ns;
                        case (i_in_data.mode)
                            MODE_START: begin
                                r_tempo    <= i_in_data.bpm_milli;
                                r_anchored <= i_in_data.bpm_milli;
                                r_anchor   <= i_in_data.event_time_ns;
                                r_next     <= '0;
                                r_cont_p   <= 1'b0;
                                r_tempo_p  <= 1'b0;
                                r_running  <= 1'b1;
                                r_status   <= ST_START;
                                r_state    <= S_EMIT;
                            end
                            MODE_CONTINUE: begin
                                r_tempo   <= i_in_data.bpm_milli;
                                r_cont_p  <= 1'b1;
                                r_running <= 1'b1;
                                r_status  <= ST_CONTINUE;
                                r_state   <= S_EMIT;
                            end
                            MODE_STOP: begin
                                r_running <= 1'b0;
                                r_status  <= ST_STOP;
                                r_state   <= S_EMIT;
                            end
                            MODE_TEMPO: begin
                                r_tempo   <= i_in_data.bpm_milli;
                                r_tempo_p <= 1'b1;
                            end
                            MODE_PUMP: begin
                                if (r_running && (r_tempo != '0)) begin
                                    r_horizon <= i_in_data.event_time_ns
                                                 + TIME_W'(r_lookahead);
                                    r_kept      <= r_anchor;
                                    r_off_req.count <= r_next;
                                    // old-tempo offset first when a tempo change is pending
                                    if (!r_cont_p && r_tempo_p && (r_anchored != '0)) begin
                                        r_off_req.tempo <= r_anchored;
                                        r_state         <= S_OLD;
                                    end else begin
                                        r_off_req.tempo <= r_tempo;
                                        r_state         <= S_NEW;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.status_byte     <= r_status;
                        r_out.message_time_ns <= r_now;
                        r_out.last            <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_OLD: begin
                    // hold the next tick's time under the old tempo
                    if (off_done) begin
                        r_kept          <= r_anchor + off_ns;
                        r_off_req.tempo <= r_tempo;
                        r_state         <= S_NEW;
                    end
                end
                S_NEW: begin
                    if (off_done) begin
                        r_q   <= off_q;
                        r_acc <= off_prod;
                        if (r_cont_p) begin
                            r_cont_p <= 1'b0;
                            r_anchor <= r_now - off_ns;
                        end else if (r_tempo_p) begin
                            r_tempo_p <= 1'b0;
                            r_anchor  <= r_kept - off_ns;
                        end
                        r_anchored <= r_tempo;
                        r_cnt      <= '0;
                        r_have     <= 1'b0;
                        r_state    <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_t     <= r_anchor + r_acc[PROD_W-1:FRAC_BITS];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // each tick is held in r_pend until the next is known, so that the final one carries last
                    if (tick_ok) begin
                        if (!r_have || out_free) begin
                            if (r_have) begin
                                r_out.status_byte     <= ST_TICK;
                                r_out.message_time_ns <= r_pend;
                                r_out.last            <= 1'b0;
                            end
                            r_pend  <= r_t;
                            r_have  <= 1'b1;
                            r_acc   <= r_acc + PROD_W'(r_q);
                            r_next  <= r_next + 1'b1;
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_CALC;
                        end
                    end else if (!r_have) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out.status_byte     <= ST_TICK;
                        r_out.message_time_ns <= r_pend;
                        r_out.last            <= 1'b1;
                        r_have  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Testbench for midi_clock_tick_scheduler: directed and random transport events,
// predicted per transaction and checked result by result. Depends on mcts_pkg.
module tb;
    import mcts_pkg::*;

    localparam int MAX_CYCLES = 2000000;
    localparam int EXP_DEPTH  = 1024;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [LOOK_W-1:0] i_cfg_data = '0;

    // Predictor state
    logic [LOOK_W-1:0]  lookahead;
    logic               running;
    logic [TEMPO_W-1:0] tempo;
    logic [TEMPO_W-1:0] anch_tempo;
    logic [TIME_W-1:0]  anchor;
    logic [COUNT_W-1:0] next_tick;
    logic               cont_pend;
    logic               tempo_pend;

    // Expected messages, oldest at exp_rd
    t_out_item exp_buf [EXP_DEPTH];
    int  exp_wr = 0;
    int  exp_rd = 0;
    int  errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_ticks = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;
    bit  hold_rx = 1'b0;
    bit  rx_idle = 1'b1;

    midi_clock_tick_scheduler DUT (.*);

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // floor(count * 2.5e12 / t) with truncated Q.16 interval, mod 2^64
    function automatic logic [TIME_W-1:0] tick_offset(logic [COUNT_W-1:0] count,
                                                      logic [TEMPO_W-1:0] t);
        logic [63:0] whole, rem, frac, n;
        whole = NS_PER_TICK / t;
        rem   = NS_PER_TICK % t;
        frac  = (rem << FRAC_BITS) / t;
        n     = 64'(count);
        return n * whole + ((n * frac) >> FRAC_BITS);
    endfunction

    function automatic int exp_count();
        return exp_wr - exp_rd;
    endfunction

    function automatic void push_msg(logic [7:0] st, logic [TIME_W-1:0] t);
        t_out_item m;
        m.status_byte = st;
        m.message_time_ns = t;
        m.last = 1'b0;
        exp_buf[exp_wr % EXP_DEPTH] = m;
        exp_wr++;
    endfunction

    // Work out the messages that one transaction causes
    function automatic void predict_event(t_in_item it);
        int start_sz, k;
        logic [TIME_W-1:0] kept, horizon, t;
        start_sz = exp_count();
        case (it.mode)
            MODE_START: begin
                tempo = it.bpm_milli; anchor = it.event_time_ns; next_tick = '0;
                cont_pend = 1'b0; tempo_pend = 1'b0; anch_tempo = it.bpm_milli;
                running = 1'b1;
                push_msg(ST_START, it.event_time_ns);
            end
            MODE_CONTINUE: begin
                tempo = it.bpm_milli; cont_pend = 1'b1; running = 1'b1;
                push_msg(ST_CONTINUE, it.event_time_ns);
            end
            MODE_STOP: begin
                running = 1'b0;
                push_msg(ST_STOP, it.event_time_ns);
            end
            MODE_TEMPO: begin
                tempo = it.bpm_milli; tempo_pend = 1'b1;
            end
            MODE_PUMP: begin
                if (running && tempo != 0) begin
                    if (cont_pend) begin
                        cont_pend = 1'b0;
                        anchor = it.event_time_ns - tick_offset(next_tick, tempo);
                    end else if (tempo_pend) begin
                        kept = anchor;
                        tempo_pend = 1'b0;
                        if (anch_tempo != 0) kept += tick_offset(next_tick, anch_tempo);
                        anchor = kept - tick_offset(next_tick, tempo);
                    end
                    anch_tempo = tempo;
                    horizon = it.event_time_ns + 64'(lookahead);
                    for (k = 0; k < MAX_TICKS; k++) begin
                        t = anchor + tick_offset(next_tick, tempo);
                        if (t > horizon) break;
                        push_msg(ST_TICK, t);
                        next_tick++;
                        n_ticks++;
                    end
                end
            end
            default: ;
        endcase
        if (exp_count() > start_sz)
            exp_buf[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
    endfunction

    // Receiver stall: random bursts, or a long hold-off on request
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            if (hold_rx) begin
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_rx = 1'b0;
                @(negedge i_clk);
            end else if (!no_idle && !rx_idle && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 6);
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                i_out_stall <= 1'b0;
                @(negedge i_clk);
            end else begin
                @(negedge i_clk);
            end
        end
    end

    // Compare each accepted message with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item exp_m;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_count() == 0) begin
                $error("unexpected message status %h time %h",
                       o_out_data.status_byte, o_out_data.message_time_ns);
                errors++;
            end else begin
                exp_m = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                n_checked++;
                if (o_out_data.status_byte !== exp_m.status_byte) begin
                    $error("status_byte expected %h actual %h",
                           exp_m.status_byte, o_out_data.status_byte);
                    errors++;
                end
                if (o_out_data.message_time_ns !== exp_m.message_time_ns) begin
                    $error("message_time_ns expected %h actual %h",
                           exp_m.message_time_ns, o_out_data.message_time_ns);
                    errors++;
                end
                if (o_out_data.last !== exp_m.last) begin
                    $error("last expected %b actual %b", exp_m.last, o_out_data.last);
                    errors++;
                end
            end
        end
    end

    // Offer one transaction, hold it until accepted, then predict
    task automatic send_event(logic [2:0] mode, logic [TIME_W-1:0] t,
                              logic [TEMPO_W-1:0] bpm);
        t_in_item it;
        it.mode = mode;
        it.event_time_ns = t;
        it.bpm_milli = bpm;
        if (!no_idle && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data = it;
        do @(posedge i_clk); while (o_in_stall);
        predict_event(it);
        n_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (exp_count() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_lookahead(logic [LOOK_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        lookahead = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [TEMPO_W-1:0] rand_bpm();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return TEMPO_W'($urandom_range(1, 50));
            2: return '1;
            3: return TEMPO_W'(1000000);
            default: return TEMPO_W'($urandom_range(20000, 300000));
        endcase
    endfunction

    // Directed: every mode, tempo extremes, pending cases, wrap and cap
    task automatic test_directed();
        logic [TIME_W-1:0] t0;
        send_event(MODE_PUMP, 64'd1000, 20'd120000);
        send_event(MODE_START, 64'd0, 20'd120000);
        send_event(MODE_PUMP, 64'd0, 20'd0);
        send_event(MODE_TEMPO, 64'd5, 20'd60000);
        send_event(MODE_PUMP, 64'd100000000, 20'd0);
        send_event(MODE_STOP, 64'd150000000, 20'd0);
        send_event(MODE_PUMP, 64'd160000000, 20'd0);
        send_event(MODE_CONTINUE, 64'd300000000, 20'd240000);
        send_event(MODE_TEMPO, 64'd0, 20'd90000);
        send_event(MODE_PUMP, 64'd300000000, 20'd0);
        send_event(MODE_PUMP, 64'd500000000, 20'd0);
        send_event(3'd5, 64'd1, 20'd1);
        send_event(3'd7, '1, '1);
        send_event(MODE_START, 64'd10, 20'd0);
        send_event(MODE_TEMPO, 64'd10, 20'd1000000);
        send_event(MODE_PUMP, 64'd20, 20'd0);
        send_event(MODE_TEMPO, 64'd20, '1);
        send_event(MODE_PUMP, 64'd30, 20'd0);
        t0 = 64'hFFFF_FFFF_FFF0_0000;
        send_event(MODE_START, t0, 20'd1000000);
        send_event(MODE_PUMP, t0, '1);
        send_event(MODE_PUMP, '1, 20'd0);
        send_event(MODE_START, 64'd0, 20'd1);
        send_event(MODE_PUMP, '1, 20'd0);
    endtask

    task automatic test_lookahead_extremes();
        write_lookahead('0);
        send_event(MODE_START, 64'd1000, 20'd120000);
        send_event(MODE_PUMP, 64'd1000, 20'd0);
        send_event(MODE_PUMP, 64'd50000000, 20'd0);
        write_lookahead(LOOK_W'(1000000000));
        send_event(MODE_PUMP, 64'd60000000, 20'd0);
        send_event(MODE_PUMP, 64'd60000000, 20'd0);
        write_lookahead('1);
        send_event(MODE_PUMP, 64'd70000000, 20'd0);
    endtask

    // Mostly well-formed sessions with random content, some noise
    task automatic test_random(int count);
        logic [TIME_W-1:0] now;
        int i, r;
        now = {$urandom, $urandom};
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            now += 64'($urandom_range(0, 40000000));
            if (r < 8) send_event(MODE_START, now, rand_bpm());
            else if (r < 14) send_event(MODE_CONTINUE, now, rand_bpm());
            else if (r < 19) send_event(MODE_STOP, now, rand_bpm());
            else if (r < 28) send_event(MODE_TEMPO, now, rand_bpm());
            else if (r < 94) send_event(MODE_PUMP, now, TEMPO_W'($urandom));
            else if (r < 97) send_event(3'($urandom_range(5, 7)), {$urandom, $urandom},
                                        TEMPO_W'($urandom));
            else send_event(3'($urandom_range(0, 4)), {$urandom, $urandom},
                            TEMPO_W'($urandom));
        end
    endtask

    // Hold the receiver off while pumps keep coming, then pause the sender
    task automatic test_backpressure();
        int i;
        hold_rx = 1'b1;
        send_event(MODE_START, 64'd0, 20'd1000000);
        for (i = 0; i < 6; i++) send_event(MODE_PUMP, 64'(i) * 64'd5000000, 20'd0);
        wait_drained();
    endtask

    initial begin
        lookahead = LOOKAHEAD_RESET;
        running = 1'b0; tempo = '0; anch_tempo = '0; anchor = '0;
        next_tick = '0; cont_pend = 1'b0; tempo_pend = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        rx_idle = 1'b0;
        test_directed();
        test_lookahead_extremes();
        write_lookahead(LOOK_W'(200000000));
        test_random(150);
        write_lookahead(LOOK_W'($urandom_range(0, 1000000000)));
        test_backpressure();
        test_random(120);
        write_lookahead(LOOK_W'(50000000));
        no_idle = 1'b1;
        test_random(60);
        wait_drained();
        $display("sent %0d transport events, checked %0d messages (%0d ticks)",
                 n_sent, n_checked, n_ticks);
        $display("covered all modes, pending continue/tempo, zero tempo, wrap, tick cap");
        if (errors == 0 && exp_count() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
